>>> src/particle_field_euler_step_top_defines.svh
// Assertion helpers for the particle Euler step block.
`ifndef PARTICLE_FIELD_EULER_STEP_TOP_DEFINES_SVH
`define PARTICLE_FIELD_EULER_STEP_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define PFES_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset.
`define PFES_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pfes_pkg.sv
`default_nettype none

package pfes_pkg;

    localparam int unsigned AREA_W = 48;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [47:0] AREA_MIN_RST = 48'hFF00_FF00_FF00;
    localparam logic [47:0] AREA_MAX_RST = 48'h0100_0100_0100;
    localparam logic [15:0] ACCEL_X_RST = 16'd3840;
    localparam logic [15:0] ACCEL_Y_RST = 16'd0;
    localparam logic [15:0] ACCEL_Z_RST = 16'd0;
    localparam logic [15:0] TIME_STEP_RST = 16'd1092;

    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AREA_MIN  = 3'd0,
        REG_AREA_MAX  = 3'd1,
        REG_ACCEL_X   = 3'd2,
        REG_ACCEL_Y   = 3'd3,
        REG_ACCEL_Z   = 3'd4,
        REG_TIME_STEP = 3'd5
    } cfg_reg_t;

    // One particle as it moves down the pipe.
    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [2:0][15:0] vel;
        logic [2:0][32:0] prod;       // Q8.24 product, signed
        logic [15:0]      age;
        logic [15:0]      life;
        logic [15:0]      rem;        // divider partial remainder
        logic [7:0]       quo;        // divider quotient bits / final alpha
        logic             in_box;
        logic             removed;
        logic             alpha_zero;
        logic             alpha_full;
    } item_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  quo;
    } div_t;

    // signed 16 x unsigned 16 -> signed 33
    function automatic logic [32:0] mul_step(input logic [15:0] a, input logic [15:0] step);
        logic signed [33:0] p;
        p = $signed({a[15], a}) * $signed({1'b0, step});
        return p[32:0];
    endfunction

    // round half up to Q8.8: (p + 2^15) >>> 16
    function automatic logic [16:0] round_prod(input logic [32:0] p);
        logic [32:0] s;
        s = p + 33'd32768;
        return s[32:16];
    endfunction

    // v + d with signed 16-bit saturation
    function automatic logic [15:0] add_sat16(input logic [15:0] v, input logic [16:0] d);
        logic [17:0] s;
        s = {{2{v[15]}}, v} + {d[16], d};
        if (s[17:15] == 3'b000 || s[17:15] == 3'b111) begin
            return s[15:0];
        end else if (s[17]) begin
            return 16'h8000;
        end else begin
            return 16'h7FFF;
        end
    endfunction

    // one restoring divide step, rem < life on entry
    function automatic div_t div_step(input div_t d, input logic [15:0] life);
        logic [16:0] r2;
        div_t        o;
        r2 = {d.rem, 1'b0};
        o.quo = {d.quo[6:0], 1'b0};
        if (r2 >= {1'b0, life}) begin
            r2 = r2 - {1'b0, life};
            o.quo[0] = 1'b1;
        end
        o.rem = r2[15:0];
        return o;
    endfunction

endpackage

`default_nettype wire

>>> src/particle_field_euler_step_top.sv
`default_nettype none
// Particle Euler step with a box-shaped force field. Takes one particle
// request per clock (position, velocity, age, life span) while s_ready is
// high and returns one result per request after five register stages:
// stage 1 checks removal, box membership and advances the age; stage 2
// forms accel * step; stage 3 updates and saturates the velocity; stage 4
// forms velocity * step; stage 5 updates and saturates the position. Fade
// alpha comes from an eight-bit restoring divider that runs two quotient
// bits per stage in stages 2 to 5. Throughput is one request per cycle
// unless the result side stalls. Each stage holds only while the stage
// after it is full and blocked, so bubbles collapse and a stalled result
// does not stop requests from filling empty stages. Configuration is a
// plain write port (cfg_addr picks the register, see pfes_pkg::cfg_reg_t)
// and must only be written while no request is in flight.
`include "particle_field_euler_step_top_defines.svh"

module particle_field_euler_step_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [pfes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pfes_pkg::AREA_W-1:0]     cfg_wdata,
    // particle requests
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [15:0]              s_pos_x,
    input  wire logic signed [15:0]              s_pos_y,
    input  wire logic signed [15:0]              s_pos_z,
    input  wire logic signed [15:0]              s_vel_x,
    input  wire logic signed [15:0]              s_vel_y,
    input  wire logic signed [15:0]              s_vel_z,
    input  wire logic [15:0]                     s_age,
    input  wire logic [15:0]                     s_life_span,
    // results
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [15:0]                   m_new_pos_x,
    output logic signed [15:0]                   m_new_pos_y,
    output logic signed [15:0]                   m_new_pos_z,
    output logic signed [15:0]                   m_new_vel_x,
    output logic signed [15:0]                   m_new_vel_y,
    output logic signed [15:0]                   m_new_vel_z,
    output logic [15:0]                          m_new_age,
    output logic [7:0]                           m_fade_alpha,
    output logic                                 m_removed
);

    localparam int unsigned NSTG = 5;

    // ---------------- configuration registers ----------------
    logic [47:0] area_min_reg;
    logic [47:0] area_max_reg;
    logic [2:0][15:0] accel_reg;
    logic [15:0] time_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_min_reg  <= pfes_pkg::AREA_MIN_RST;
            area_max_reg  <= pfes_pkg::AREA_MAX_RST;
            accel_reg[0]  <= pfes_pkg::ACCEL_X_RST;
            accel_reg[1]  <= pfes_pkg::ACCEL_Y_RST;
            accel_reg[2]  <= pfes_pkg::ACCEL_Z_RST;
            time_step_reg <= pfes_pkg::TIME_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (pfes_pkg::cfg_reg_t'(cfg_addr))
                pfes_pkg::REG_AREA_MIN:  area_min_reg  <= cfg_wdata;
                pfes_pkg::REG_AREA_MAX:  area_max_reg  <= cfg_wdata;
                pfes_pkg::REG_ACCEL_X:   accel_reg[0]  <= cfg_wdata[15:0];
                pfes_pkg::REG_ACCEL_Y:   accel_reg[1]  <= cfg_wdata[15:0];
                pfes_pkg::REG_ACCEL_Z:   accel_reg[2]  <= cfg_wdata[15:0];
                pfes_pkg::REG_TIME_STEP: time_step_reg <= cfg_wdata[15:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    // stage k loads when it is empty or stage k+1 loads this cycle
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_ready = adv[0];

    pfes_pkg::item_t st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    pfes_pkg::item_t st1_next, st2_next, st3_next, st4_next, st5_next;

    // ---------------- stage 1: removal, box test, age ----------------
    logic [16:0] age_sum;
    logic [15:0] age_new;
    logic [12:0] age_inc;
    logic [16:0] step_rnd;
    logic [2:0]  axis_in;

    always_comb begin
        step_rnd = {1'b0, time_step_reg} + 17'd8;
        age_inc  = step_rnd[16:4];
        age_sum  = {1'b0, s_age} + {4'd0, age_inc};
        age_new  = age_sum[16] ? 16'hFFFF : age_sum[15:0];

        axis_in[0] = ($signed(s_pos_x) >= $signed(area_min_reg[15:0]))
                  && ($signed(s_pos_x) <= $signed(area_max_reg[15:0]));
        axis_in[1] = ($signed(s_pos_y) >= $signed(area_min_reg[31:16]))
                  && ($signed(s_pos_y) <= $signed(area_max_reg[31:16]));
        axis_in[2] = ($signed(s_pos_z) >= $signed(area_min_reg[47:32]))
                  && ($signed(s_pos_z) <= $signed(area_max_reg[47:32]));

        st1_next            = '0;
        st1_next.pos[0]     = s_pos_x;
        st1_next.pos[1]     = s_pos_y;
        st1_next.pos[2]     = s_pos_z;
        st1_next.vel[0]     = s_vel_x;
        st1_next.vel[1]     = s_vel_y;
        st1_next.vel[2]     = s_vel_z;
        st1_next.life       = s_life_span;
        st1_next.removed    = (s_life_span <= s_age);
        st1_next.in_box     = &axis_in;
        st1_next.age        = st1_next.removed ? s_age : age_new;
        st1_next.alpha_zero = st1_next.removed || (age_new >= s_life_span);
        // new age of zero means the ratio is exactly one
        st1_next.alpha_full = (age_new == 16'd0);
        st1_next.rem        = s_life_span - age_new;
        st1_next.quo        = '0;
    end

    // ---------------- stage 2: accel * step ----------------
    pfes_pkg::div_t dv2a, dv2b;

    always_comb begin
        st2_next = st1_reg;
        for (int i = 0; i < 3; i++) begin
            st2_next.prod[i] = pfes_pkg::mul_step(accel_reg[i], time_step_reg);
        end
        dv2a = pfes_pkg::div_step('{rem: st1_reg.rem, quo: st1_reg.quo}, st1_reg.life);
        dv2b = pfes_pkg::div_step(dv2a, st1_reg.life);
        st2_next.rem = dv2b.rem;
        st2_next.quo = dv2b.quo;
    end

    // ---------------- stage 3: velocity update ----------------
    pfes_pkg::div_t dv3a, dv3b;

    always_comb begin
        st3_next = st2_reg;
        if (st2_reg.in_box && !st2_reg.removed) begin
            for (int i = 0; i < 3; i++) begin
                st3_next.vel[i] = pfes_pkg::add_sat16(st2_reg.vel[i],
                                      pfes_pkg::round_prod(st2_reg.prod[i]));
            end
        end
        dv3a = pfes_pkg::div_step('{rem: st2_reg.rem, quo: st2_reg.quo}, st2_reg.life);
        dv3b = pfes_pkg::div_step(dv3a, st2_reg.life);
        st3_next.rem = dv3b.rem;
        st3_next.quo = dv3b.quo;
    end

    // ---------------- stage 4: velocity * step ----------------
    pfes_pkg::div_t dv4a, dv4b;

    always_comb begin
        st4_next = st3_reg;
        for (int i = 0; i < 3; i++) begin
            st4_next.prod[i] = pfes_pkg::mul_step(st3_reg.vel[i], time_step_reg);
        end
        dv4a = pfes_pkg::div_step('{rem: st3_reg.rem, quo: st3_reg.quo}, st3_reg.life);
        dv4b = pfes_pkg::div_step(dv4a, st3_reg.life);
        st4_next.rem = dv4b.rem;
        st4_next.quo = dv4b.quo;
    end

    // ---------------- stage 5: position update, alpha ----------------
    pfes_pkg::div_t dv5a, dv5b;

    always_comb begin
        st5_next = st4_reg;
        if (!st4_reg.removed) begin
            for (int i = 0; i < 3; i++) begin
                st5_next.pos[i] = pfes_pkg::add_sat16(st4_reg.pos[i],
                                      pfes_pkg::round_prod(st4_reg.prod[i]));
            end
        end
        dv5a = pfes_pkg::div_step('{rem: st4_reg.rem, quo: st4_reg.quo}, st4_reg.life);
        dv5b = pfes_pkg::div_step(dv5a, st4_reg.life);
        st5_next.rem = dv5b.rem;
        if (st4_reg.alpha_zero) begin
            st5_next.quo = 8'd0;
        end else if (st4_reg.alpha_full) begin
            st5_next.quo = pfes_pkg::ALPHA_MAX;
        end else begin
            st5_next.quo = dv5b.quo;
        end
    end

    // ---------------- stage registers (payload, no reset) ----------------
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
        if (adv[3]) begin
            st4_reg <= st4_next;
        end
        if (adv[4]) begin
            st5_reg <= st5_next;
        end
    end

    // ---------------- result channel ----------------
    assign m_valid      = vld_reg[NSTG-1];
    assign m_new_pos_x  = st5_reg.pos[0];
    assign m_new_pos_y  = st5_reg.pos[1];
    assign m_new_pos_z  = st5_reg.pos[2];
    assign m_new_vel_x  = st5_reg.vel[0];
    assign m_new_vel_y  = st5_reg.vel[1];
    assign m_new_vel_z  = st5_reg.vel[2];
    assign m_new_age    = st5_reg.age;
    assign m_fade_alpha = st5_reg.quo;
    assign m_removed    = st5_reg.removed;

    // ---------------- assertions ----------------
    `PFES_ASSERT_IMPLY(a_removed_no_alpha, aclk, aresetn, m_valid && m_removed, m_fade_alpha == 8'd0, "removed particle with nonzero alpha")
    `PFES_ASSERT_IMPLY(a_stall_only_when_full, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled while output not blocked")
    `PFES_ASSERT_NEXT(a_reset_empties, aclk, !aresetn, !m_valid, "result valid right after reset")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Run limits. CYCLE_LIMIT lies well above the slowest legal run, so the
    // watchdog only fires if the block hangs.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned ITEMS_PER_PHASE = 100;

    // Full-range box: every Q8.8 position is inside.
    localparam logic [47:0] FULL_MIN = 48'h8000_8000_8000;
    localparam logic [47:0] FULL_MAX = 48'h7FFF_7FFF_7FFF;

    // One particle request. Index 0/1/2 of pos and vel is x/y/z.
    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [2:0][15:0] vel;
        logic [15:0]      age;
        logic [15:0]      life_span;
    } particle_t;

    typedef struct packed {
        logic [2:0][15:0] pos;
        logic [2:0][15:0] vel;
        logic [15:0]      age;
        logic [7:0]       fade_alpha;
        logic             removed;
    } step_result_t;

    typedef struct packed {
        logic [47:0] area_min;
        logic [47:0] area_max;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] time_step;
    } field_cfg_t;

    // Random phases, each run under its own register setting.
    typedef enum int {
        PH_RANDOM,
        PH_STEADY,
        PH_NEG_EXTREME,
        PH_POS_EXTREME,
        PH_INVERTED,
        PH_TINY_STEP
    } phase_kind_t;

    // Predicts each accepted request and checks results in order.
    class euler_step_scoreboard;
        logic [47:0]      area_min;
        logic [47:0]      area_max;
        logic [2:0][15:0] accel;
        logic [15:0]      time_step;
        step_result_t     expected_steps [$];
        int unsigned      errors;

        function new();
            area_min  = pfes_pkg::AREA_MIN_RST;
            area_max  = pfes_pkg::AREA_MAX_RST;
            accel     = {pfes_pkg::ACCEL_Z_RST, pfes_pkg::ACCEL_Y_RST,
                         pfes_pkg::ACCEL_X_RST};
            time_step = pfes_pkg::TIME_STEP_RST;
            errors    = 0;
        endfunction

        function void set_reg(pfes_pkg::cfg_reg_t r, logic [47:0] v);
            case (r)
                pfes_pkg::REG_AREA_MIN:  area_min  = v;
                pfes_pkg::REG_AREA_MAX:  area_max  = v;
                pfes_pkg::REG_ACCEL_X:   accel[0]  = v[15:0];
                pfes_pkg::REG_ACCEL_Y:   accel[1]  = v[15:0];
                pfes_pkg::REG_ACCEL_Z:   accel[2]  = v[15:0];
                pfes_pkg::REG_TIME_STEP: time_step = v[15:0];
                default: ;
            endcase
        endfunction

        // round(a * step / 2^16), half up
        function longint scaled(logic [15:0] a, logic [15:0] step);
            longint prod;
            prod = longint'($signed(a)) * longint'({48'b0, step}) + 64'sd32768;
            return prod >>> 16;
        endfunction

        function logic [15:0] clamp16(longint v);
            if (v > 32767) return 16'h7FFF;
            if (v < -32768) return 16'h8000;
            return v[15:0];
        endfunction

        function step_result_t predict_step(particle_t p);
            step_result_t r;
            logic         in_box;
            int unsigned  age_next;
            int unsigned  ratio;
            r.pos        = p.pos;
            r.vel        = p.vel;
            r.age        = p.age;
            r.fade_alpha = '0;
            r.removed    = 1'b1;
            // expired or zero-life particles pass through untouched
            if (p.life_span <= p.age) return r;
            r.removed = 1'b0;
            in_box = 1'b1;
            for (int i = 0; i < 3; i++) begin
                if ($signed(p.pos[i]) < $signed(area_min[16*i +: 16]) ||
                    $signed(p.pos[i]) > $signed(area_max[16*i +: 16]))
                    in_box = 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                if (in_box)
                    r.vel[i] = clamp16($signed(p.vel[i]) + scaled(accel[i], time_step));
                r.pos[i] = clamp16($signed(p.pos[i]) + scaled(r.vel[i], time_step));
            end
            age_next = p.age + ((time_step + 8) >> 4);
            if (age_next > 65535) age_next = 65535;
            r.age = age_next[15:0];
            if (age_next < p.life_span) begin
                ratio = ((p.life_span - age_next) * 256) / p.life_span;
                r.fade_alpha = (ratio > 255) ? 8'hFF : ratio[7:0];
            end
            return r;
        endfunction

        function void note_request(particle_t p);
            expected_steps.insert(expected_steps.size(), predict_step(p));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function void compare_field(string name, logic signed [31:0] want_v,
                                    logic signed [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            string        axis [3] = '{"x", "y", "z"};
            if (expected_steps.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            for (int i = 0; i < 3; i++) begin
                compare_field({"new_pos_", axis[i]}, $signed(want.pos[i]), $signed(got.pos[i]));
                compare_field({"new_vel_", axis[i]}, $signed(want.vel[i]), $signed(got.vel[i]));
            end
            compare_field("new_age", want.age, got.age);
            compare_field("fade_alpha", want.fade_alpha, got.fade_alpha);
            compare_field("removed", want.removed, got.removed);
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;

    logic                            cfg_wr_en;
    logic [pfes_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [pfes_pkg::AREA_W-1:0]     cfg_wdata;

    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_pos_x, s_pos_y, s_pos_z;
    logic [15:0] s_vel_x, s_vel_y, s_vel_z;
    logic [15:0] s_age, s_life_span;

    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_new_pos_x, m_new_pos_y, m_new_pos_z;
    logic [15:0] m_new_vel_x, m_new_vel_y, m_new_vel_z;
    logic [15:0] m_new_age;
    logic [7:0]  m_fade_alpha;
    logic        m_removed;

    // steady: neither side idles. hold_off_req: receiver stalls for a long
    // stretch, counted in its own process.
    bit          steady = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned cycle_count = 0;
    field_cfg_t  cur_cfg;

    euler_step_scoreboard euler_sb = new();

    particle_field_euler_step_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_vel_x      (s_vel_x),
        .s_vel_y      (s_vel_y),
        .s_vel_z      (s_vel_z),
        .s_age        (s_age),
        .s_life_span  (s_life_span),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_pos_x  (m_new_pos_x),
        .m_new_pos_y  (m_new_pos_y),
        .m_new_pos_z  (m_new_pos_z),
        .m_new_vel_x  (m_new_vel_x),
        .m_new_vel_y  (m_new_vel_y),
        .m_new_vel_z  (m_new_vel_z),
        .m_new_age    (m_new_age),
        .m_fade_alpha (m_fade_alpha),
        .m_removed    (m_removed)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: ready toggles at random (about a third of cycles idle)
    // unless steady, or drops for HOLD_CYCLES when a hold-off is asked for.
    initial begin : result_ready
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 34);
            end
        end
    end

    // Every accepted result goes to the scoreboard. Signals are sampled
    // as they stood before this edge, since all drivers use NBAs.
    always @(posedge aclk) begin : result_monitor
        step_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pos        = {m_new_pos_z, m_new_pos_y, m_new_pos_x};
            got.vel        = {m_new_vel_z, m_new_vel_y, m_new_vel_x};
            got.age        = m_new_age;
            got.fade_alpha = m_fade_alpha;
            got.removed    = m_removed;
            euler_sb.check_result(got);
        end
    end

    function automatic particle_t make_particle(int px, int py, int pz, int vx, int vy,
                                                int vz, int age, int life);
        particle_t p;
        p.pos       = {16'(pz), 16'(py), 16'(px)};
        p.vel       = {16'(vz), 16'(vy), 16'(vx)};
        p.age       = 16'(age);
        p.life_span = 16'(life);
        return p;
    endfunction

    function automatic field_cfg_t make_cfg(logic [47:0] amin, logic [47:0] amax,
                                            logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] az, logic [15:0] step);
        field_cfg_t c;
        c.area_min  = amin;
        c.area_max  = amax;
        c.accel_x   = ax;
        c.accel_y   = ay;
        c.accel_z   = az;
        c.time_step = step;
        return c;
    endfunction

    // Q8.8 value: small or anything about equally often, sometimes an extreme.
    function automatic logic [15:0] rand_q88();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3, 4, 5: return 16'($urandom_range(0, 2048) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    // Half the requests land inside the current box (when it is not
    // inverted), a quarter sit on or just past its edges, the rest roam.
    function automatic particle_t rand_particle(field_cfg_t c);
        particle_t   p;
        int          lo, hi;
        int unsigned sel, a, l;
        sel = $urandom_range(3);
        for (int i = 0; i < 3; i++) begin
            lo = $signed(c.area_min[16*i +: 16]);
            hi = $signed(c.area_max[16*i +: 16]);
            if (sel <= 1 && lo <= hi)
                p.pos[i] = 16'(lo + int'($urandom_range(0, hi - lo)));
            else if (sel == 2)
                case ($urandom_range(3))
                    0: p.pos[i] = 16'(lo);
                    1: p.pos[i] = 16'(hi);
                    2: p.pos[i] = 16'(lo - 1);
                    default: p.pos[i] = 16'(hi + 1);
                endcase
            else
                p.pos[i] = rand_q88();
            p.vel[i] = rand_q88();
        end
        // age vs life span: expired, about to expire, fresh, or anywhere
        case ($urandom_range(9))
            0, 1: begin
                a = $urandom_range(0, 65535);
                l = $urandom_range(0, a);
            end
            2: begin
                l = $urandom_range(1, 65535);
                a = l - $urandom_range(1, (l < 300) ? l : 300);
            end
            3: begin
                a = 0;
                l = $urandom_range(1, 65535);
            end
            default: begin
                l = $urandom_range(1, 65535);
                a = $urandom_range(0, l - 1);
            end
        endcase
        p.age       = a[15:0];
        p.life_span = l[15:0];
        return p;
    endfunction

    function automatic field_cfg_t phase_config(phase_kind_t kind);
        field_cfg_t c;
        int         lo, hi;
        c.accel_x   = 16'($urandom);
        c.accel_y   = 16'($urandom);
        c.accel_z   = 16'($urandom);
        c.time_step = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
            lo = int'($urandom_range(0, 2048)) - 1024;
            hi = lo + int'($urandom_range(0, 1024));
            if (kind == PH_INVERTED)
                hi = lo - 1 - int'($urandom_range(0, 512));
            c.area_min[16*i +: 16] = 16'(lo);
            c.area_max[16*i +: 16] = 16'(hi);
        end
        case (kind)
            PH_NEG_EXTREME: c = make_cfg(FULL_MIN, FULL_MAX, 16'h8000, 16'h8000,
                                         16'h8000, 16'hFFFF);
            PH_POS_EXTREME: c = make_cfg(FULL_MIN, FULL_MAX, 16'h7FFF, 16'h7FFF,
                                         16'h7FFF, 16'hFFFF);
            // age increment of zero or one
            PH_TINY_STEP: c.time_step = 16'($urandom_range(0, 23));
            default: ;
        endcase
        return c;
    endfunction

    // One register write per clock; the caller drops the enable afterwards.
    task automatic write_reg(input pfes_pkg::cfg_reg_t r, input logic [47:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        euler_sb.set_reg(r, v);
    endtask

    // Only called with nothing in flight.
    task automatic apply_config(input field_cfg_t c);
        write_reg(pfes_pkg::REG_AREA_MIN, c.area_min);
        write_reg(pfes_pkg::REG_AREA_MAX, c.area_max);
        write_reg(pfes_pkg::REG_ACCEL_X, {32'b0, c.accel_x});
        write_reg(pfes_pkg::REG_ACCEL_Y, {32'b0, c.accel_y});
        write_reg(pfes_pkg::REG_ACCEL_Z, {32'b0, c.accel_z});
        write_reg(pfes_pkg::REG_TIME_STEP, {32'b0, c.time_step});
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    // Offer one request and hold it until accepted. Valid is only dropped
    // for an idle gap, so back-to-back requests keep it high.
    task automatic send_particle(input particle_t p);
        if (!steady) begin
            while ($urandom_range(99) < 34) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_pos_x     <= p.pos[0];
        s_pos_y     <= p.pos[1];
        s_pos_z     <= p.pos[2];
        s_vel_x     <= p.vel[0];
        s_vel_y     <= p.vel[1];
        s_vel_z     <= p.vel[2];
        s_age       <= p.age;
        s_life_span <= p.life_span;
        do @(posedge aclk); while (!s_ready);
        euler_sb.note_request(p);
    endtask

    // Stop offering and wait until every outstanding request has returned.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (euler_sb.pending() != 0);
    endtask

    initial begin : stimulus
        particle_t   directed [$];
        phase_kind_t kind;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_pos_x     = '0;
        s_pos_y     = '0;
        s_pos_z     = '0;
        s_vel_x     = '0;
        s_vel_y     = '0;
        s_vel_z     = '0;
        s_age       = '0;
        s_life_span = '0;
        cur_cfg = make_cfg(pfes_pkg::AREA_MIN_RST, pfes_pkg::AREA_MAX_RST,
                           pfes_pkg::ACCEL_X_RST, pfes_pkg::ACCEL_Y_RST,
                           pfes_pkg::ACCEL_Z_RST, pfes_pkg::TIME_STEP_RST);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset settings: box is +/-1.0, field pushes along x.
        directed = '{
            make_particle(0, 0, 0, 0, 0, 0, 'h4000, 'h4000),              // age == life
            make_particle('h1234, 'hEDCB, 'h7FFF, 'h8000, 'h7FFF, 1, 0, 0), // zero life
            make_particle('h8000, 'h8000, 'h8000, 'h7FFF, 'h7FFF, 'h7FFF, 'hFFFF, 0),
            make_particle(256, -256, 256, 0, 0, 0, 0, 'h4000),            // on box corners
            make_particle(-256, 256, -256, 0, 0, 0, 0, 'h4000),
            make_particle(257, 0, 0, 0, 0, 0, 0, 'h4000),                 // just outside
            make_particle(0, 0, 0, 'h7FFF, 'h8000, 'h7FFF, 0, 'hFFFF),    // velocity clamps
            make_particle('h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 100, 200),
            make_particle('h8000, 'h8000, 'h8000, 'h8000, 'h8000, 'h8000, 100, 200),
            make_particle(0, 0, 0, 16, -16, 0, 'h3FFF, 'h4000),           // reaches life
            make_particle(0, 0, 0, 0, 0, 0, 65530, 65535),                // age clamps
            make_particle(0, 0, 0, 0, 0, 0, 0, 1)
        };
        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        // Step too short to advance the age: a particle of age zero gets alpha 255.
        apply_config(make_cfg(pfes_pkg::AREA_MIN_RST, pfes_pkg::AREA_MAX_RST,
                              pfes_pkg::ACCEL_X_RST, pfes_pkg::ACCEL_Y_RST,
                              pfes_pkg::ACCEL_Z_RST, 16'd3));
        directed = '{
            make_particle(0, 0, 0, 0, 0, 0, 0, 100),
            make_particle(0, 0, 0, 0, 0, 0, 5, 10)
        };
        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        // Inverted box: nothing inside, velocity must be untouched.
        apply_config(make_cfg(48'h0100_0100_0100, 48'hFF00_FF00_FF00, 16'h1000,
                              16'hF000, 16'h0800, 16'h8000));
        directed = '{
            make_particle(0, 0, 0, 'h100, 'h100, 'h100, 0, 'h1000),
            make_particle('h100, 0, 0, 0, 0, 0, 0, 'h1000)
        };
        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        // Extremes of acceleration and step with a box covering everything.
        apply_config(make_cfg(FULL_MIN, FULL_MAX, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
        directed = '{
            make_particle(0, 0, 0, 0, 0, 0, 0, 'hFFFF),
            make_particle('h7FFF, 'h8000, 0, 'h8000, 'h7FFF, 0, 0, 'hFFFF)
        };
        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        apply_config(make_cfg(FULL_MIN, FULL_MAX, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        directed = '{
            make_particle(0, 0, 0, 'h7FFF, 0, 'h8000, 0, 2),
            make_particle('h8000, 'h7FFF, 0, 0, 0, 0, 'hFFFE, 'hFFFF)
        };
        foreach (directed[i]) send_particle(directed[i]);
        wait_drained();

        // Random phases, one register setting each.
        for (int ph = 0; ph <= PH_TINY_STEP; ph++) begin
            kind = phase_kind_t'(ph);
            apply_config(phase_config(kind));
            // no idling on either side through the steady and the
            // hold-off phases; in the latter the pipe fills and stalls
            steady = (kind == PH_STEADY || kind == PH_NEG_EXTREME);
            if (kind == PH_NEG_EXTREME) hold_off_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender pauses mid-phase until everything is back
                if (kind == PH_TINY_STEP && n == ITEMS_PER_PHASE / 2) wait_drained();
                send_particle(rand_particle(cur_cfg));
            end
            wait_drained();
            steady = 1'b0;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (euler_sb.errors == 0 && euler_sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> particle_field_euler_step_top.f
+incdir+src
src/pfes_pkg.sv
src/particle_field_euler_step_top.sv
tb/testbench.sv
